// File: sv/csrgb_pkg.sv
`default_nettype none
package csrgb_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_CLAP_THRESHOLD   = 2'd0,
    REG_SAMPLE_WINDOW_MS = 2'd1,
    REG_CLAP_WINDOW_MS   = 2'd2
  } reg_index_t;

  localparam int SampleWidth = 10;
  localparam int TimerWidth  = 16;
  localparam int ColorWidth  = 3;
  localparam int LevelWidth  = 8;

  localparam logic [SampleWidth-1:0] ThresholdReset    = 10'd920;
  localparam logic [TimerWidth-1:0]  SampleWindowReset = 16'd250;
  localparam logic [TimerWidth-1:0]  ClapWindowReset   = 16'd500;

  localparam logic [SampleWidth-1:0] SampleMax  = 10'd1023;
  localparam logic [ColorWidth-1:0]  LastColor  = 3'd6;
  localparam logic [1:0]             ClapsMax   = 2'd3;
  localparam logic [1:0]             ClapsOne   = 2'd1;
  localparam logic [1:0]             ClapsTwo   = 2'd2;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [SampleWidth-1:0] clap_threshold;
    logic [TimerWidth-1:0]  sample_window_ms;
    logic [TimerWidth-1:0]  clap_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [LevelWidth-1:0] red;
    logic [LevelWidth-1:0] green;
    logic [LevelWidth-1:0] blue;
  } rgb_t;

  // seven-color table, unused code drives white
  function automatic rgb_t palette(input logic [ColorWidth-1:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{8'd255, 8'd255, 8'd255};
      3'd1:    c = '{8'd255, 8'd255, 8'd0};
      3'd2:    c = '{8'd255, 8'd0,   8'd0};
      3'd3:    c = '{8'd255, 8'd0,   8'd255};
      3'd4:    c = '{8'd0,   8'd255, 8'd255};
      3'd5:    c = '{8'd0,   8'd255, 8'd0};
      3'd6:    c = '{8'd0,   8'd0,   8'd255};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/csrgb_apb_regs.sv
`default_nettype none
module csrgb_apb_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output csrgb_pkg::cfg_t  cfg
);
  import csrgb_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clap_threshold   <= ThresholdReset;
      cfg.sample_window_ms <= SampleWindowReset;
      cfg.clap_window_ms   <= ClapWindowReset;
    end else if (wr_en) begin
      case (idx)
        REG_CLAP_THRESHOLD:   cfg.clap_threshold   <= pwdata[SampleWidth-1:0];
        REG_SAMPLE_WINDOW_MS: cfg.sample_window_ms <= pwdata[TimerWidth-1:0];
        REG_CLAP_WINDOW_MS:   cfg.clap_window_ms   <= pwdata[TimerWidth-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_CLAP_THRESHOLD:   prdata = {{(32-SampleWidth){1'b0}}, cfg.clap_threshold};
      REG_SAMPLE_WINDOW_MS: prdata = {{(32-TimerWidth){1'b0}}, cfg.sample_window_ms};
      REG_CLAP_WINDOW_MS:   prdata = {{(32-TimerWidth){1'b0}}, cfg.clap_window_ms};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/clap_switch_rgb_controller.sv
`default_nettype none
// Clap switch with RGB lamp. Each stream request carries a 10-bit microphone
// sample and a millisecond tick. Samples are gathered into a sampling window
// whose peak-to-peak value is compared with clap_threshold when the window
// closes; a larger value counts a clap. When the clap window expires, two
// claps toggle the lamp and one clap with the lamp on steps to the next of
// seven colors. One result request comes out for every input request. The
// block takes one request per cycle while the output side keeps up: a request
// is held in the input register, the state update and result are computed in
// one pass and land in the output register. Registers (APB, byte addresses):
// 0x0 clap_threshold, 0x4 sample_window_ms, 0x8 clap_window_ms.
module clap_switch_rgb_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // sample[9:0], ms_tick[10], zero fill
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // red_level[7:0], green_level[15:8],
                                      // blue_level[23:16], light_on[24],
                                      // color_index[27:25], peak_to_peak[37:28],
                                      // window_closed[38], clap_seen[39]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import csrgb_pkg::*;

  cfg_t cfg;

  csrgb_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic                   in_valid;
  logic [SampleWidth-1:0] in_sample;
  logic                   in_tick;
  logic                   advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[SampleWidth-1:0];
      in_tick   <= s_tdata[SampleWidth];
    end
  end

  // detector state
  logic [TimerWidth-1:0]  sample_timer, sample_timer_next;
  logic [SampleWidth-1:0] window_max, window_max_next;
  logic [SampleWidth-1:0] window_min, window_min_next;
  logic                   window_has_sample, window_has_sample_next;
  logic [TimerWidth-1:0]  clap_timer, clap_timer_next;
  logic [1:0]             clap_count, clap_count_next;
  logic                   lamp_on, lamp_on_next;
  logic [ColorWidth-1:0]  current_color, current_color_next;
  logic [SampleWidth-1:0] last_p2p, last_p2p_next;

  logic [TimerWidth:0]    s_sum;
  logic [TimerWidth:0]    c_sum;
  logic                   closed;
  logic                   clap;

  // one pass over the state for the item in the input register
  always_comb begin
    s_sum = {1'b0, sample_timer} + {{TimerWidth{1'b0}}, in_tick};
    c_sum = {1'b0, clap_timer} + {{TimerWidth{1'b0}}, in_tick};
    closed = 1'b0;
    clap   = 1'b0;
    sample_timer_next      = sample_timer;
    window_max_next        = window_max;
    window_min_next        = window_min;
    window_has_sample_next = window_has_sample;
    clap_count_next        = clap_count;
    lamp_on_next           = lamp_on;
    current_color_next     = current_color;
    last_p2p_next          = last_p2p;

    // sampling window
    if (s_sum < {1'b0, cfg.sample_window_ms}) begin
      sample_timer_next = s_sum[TimerWidth-1:0];
      if (in_sample > window_max) window_max_next = in_sample;
      if (in_sample < window_min) window_min_next = in_sample;
      window_has_sample_next = 1'b1;
    end else begin
      closed = 1'b1;
      if (window_has_sample && window_max >= window_min) begin
        last_p2p_next = window_max - window_min;
      end else begin
        last_p2p_next = '0;
      end
      sample_timer_next      = '0;
      window_max_next        = '0;
      window_min_next        = SampleMax;
      window_has_sample_next = 1'b0;
      if (last_p2p_next > cfg.clap_threshold) begin
        clap = 1'b1;
        // first clap of a burst restarts the clap window
        if (clap_count == 2'd0) c_sum = '0;
        if (clap_count != ClapsMax) clap_count_next = clap_count + 2'd1;
      end
    end

    // clap window expiry
    if (c_sum > {1'b0, cfg.clap_window_ms}) begin
      clap_timer_next = '0;
      if (clap_count_next == ClapsTwo) begin
        lamp_on_next = !lamp_on;
      end else if (clap_count_next == ClapsOne && lamp_on) begin
        current_color_next = (current_color >= LastColor) ? '0 : current_color + 3'd1;
      end
      clap_count_next = '0;
    end else begin
      clap_timer_next = c_sum[TimerWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_timer      <= '0;
      window_max        <= '0;
      window_min        <= SampleMax;
      window_has_sample <= 1'b0;
      clap_timer        <= '0;
      clap_count        <= '0;
      lamp_on           <= 1'b1;
      current_color     <= '0;
      last_p2p          <= '0;
    end else if (advance) begin
      sample_timer      <= sample_timer_next;
      window_max        <= window_max_next;
      window_min        <= window_min_next;
      window_has_sample <= window_has_sample_next;
      clap_timer        <= clap_timer_next;
      clap_count        <= clap_count_next;
      lamp_on           <= lamp_on_next;
      current_color     <= current_color_next;
      last_p2p          <= last_p2p_next;
    end
  end

  // result register
  rgb_t color;

  always_comb begin
    color = palette(current_color_next);
    if (!lamp_on_next) color = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {clap, closed, last_p2p_next, current_color_next, lamp_on_next,
                  color.blue, color.green, color.red};
    end
  end

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import csrgb_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;

  // result request layout, lowest field last
  typedef struct packed {
    logic                   clap_seen;
    logic                   window_closed;
    logic [SampleWidth-1:0] peak_to_peak;
    logic [ColorWidth-1:0]  color_index;
    logic                   light_on;
    logic [LevelWidth-1:0]  blue_level;
    logic [LevelWidth-1:0]  green_level;
    logic [LevelWidth-1:0]  red_level;
  } lamp_result_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    reg_index_t             idx;
    logic [TimerWidth-1:0]  value;
    logic [SampleWidth-1:0] sample;
    logic                   tick;
    logic                   typed;
    lamp_result_t           result;
  } plan_row_t;

  localparam lamp_result_t ResetResult = '{
    clap_seen: 1'b0, window_closed: 1'b0, peak_to_peak: 10'd0, color_index: 3'd0,
    light_on: 1'b1, blue_level: 8'd255, green_level: 8'd255, red_level: 8'd255
  };

  // lamp colors, red in the top byte
  localparam rgb_t ColorTable [8] = '{
    24'hFFFFFF, 24'hFFFF00, 24'hFF0000, 24'hFF00FF,
    24'h00FFFF, 24'h00FF00, 24'h0000FF, 24'hFFFFFF
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clap_switch_rgb_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // own copy of the lamp state and settings
  cfg_t                   cfg = '{ThresholdReset, SampleWindowReset, ClapWindowReset};
  logic [TimerWidth-1:0]  ms_in_window = '0;
  logic [TimerWidth-1:0]  ms_in_burst = '0;
  logic [SampleWidth-1:0] loud_max = '0;
  logic [SampleWidth-1:0] loud_min = SampleMax;
  logic [SampleWidth-1:0] held_p2p = '0;
  logic                   window_used = 1'b0;
  logic [1:0]             burst_claps = '0;
  logic                   lamp = 1'b1;
  logic [ColorWidth-1:0]  color = '0;

  lamp_result_t lamp_results_due [$];
  logic         idle_en = 1'b1;
  int           errors = 0;
  int           cycles = 0;
  int           n_requests = 0;
  int           n_writes = 0;
  int           n_closed = 0;
  int           n_claps = 0;
  int           n_dark = 0;

  // advance the lamp state by one sample and give the result it causes
  function automatic lamp_result_t next_lamp_result(input logic [SampleWidth-1:0] smp,
                                                    input logic tick);
    logic [TimerWidth:0] s_next;
    logic [TimerWidth:0] c_next;
    lamp_result_t        r;
    s_next = {1'b0, ms_in_window} + {{TimerWidth{1'b0}}, tick};
    c_next = {1'b0, ms_in_burst} + {{TimerWidth{1'b0}}, tick};
    r = '0;
    if (s_next < {1'b0, cfg.sample_window_ms}) begin
      ms_in_window = s_next[TimerWidth-1:0];
      if (smp > loud_max) loud_max = smp;
      if (smp < loud_min) loud_min = smp;
      window_used = 1'b1;
    end else begin
      // window closes, this sample is dropped
      r.window_closed = 1'b1;
      held_p2p = (window_used && loud_max >= loud_min) ? loud_max - loud_min : '0;
      ms_in_window = '0;
      loud_max = '0;
      loud_min = SampleMax;
      window_used = 1'b0;
      if (held_p2p > cfg.clap_threshold) begin
        r.clap_seen = 1'b1;
        if (burst_claps == 2'd0) c_next = '0;
        if (burst_claps != ClapsMax) burst_claps = burst_claps + 2'd1;
      end
    end
    // clap window expiry acts on the count
    if (c_next > {1'b0, cfg.clap_window_ms}) begin
      ms_in_burst = '0;
      if (burst_claps == ClapsTwo) lamp = ~lamp;
      else if (burst_claps == ClapsOne && lamp)
        color = (color >= LastColor) ? '0 : color + 3'd1;
      burst_claps = '0;
    end else begin
      ms_in_burst = c_next[TimerWidth-1:0];
    end
    r.light_on = lamp;
    r.color_index = color;
    r.peak_to_peak = held_p2p;
    if (lamp) {r.red_level, r.green_level, r.blue_level} = ColorTable[color];
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [TimerWidth-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CLAP_THRESHOLD:   cfg.clap_threshold = value[SampleWidth-1:0];
      REG_SAMPLE_WINDOW_MS: cfg.sample_window_ms = value;
      REG_CLAP_WINDOW_MS:   cfg.clap_window_ms = value;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // offer one sample request, record what it should produce once accepted
  task automatic send_sample(input logic [SampleWidth-1:0] smp, input logic tick,
                             input logic typed, input lamp_result_t want);
    int           gap;
    lamp_result_t predicted;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {5'd0, tick, smp};
    do @(posedge clk); while (!s_tready);
    predicted = next_lamp_result(smp, tick);
    lamp_results_due.push_back(typed ? want : predicted);
    n_requests++;
    @(negedge clk);
  endtask

  // let every outstanding result come out, then settle
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (lamp_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    lamp_result_t got;
    lamp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (lamp_results_due.size() == 0) begin
        $error("result request with none outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = lamp_results_due.pop_front();
        if (got.red_level !== want.red_level) begin
          $error("red_level: expected %0d, got %0d", want.red_level, got.red_level);
          errors++;
        end
        if (got.green_level !== want.green_level) begin
          $error("green_level: expected %0d, got %0d", want.green_level, got.green_level);
          errors++;
        end
        if (got.blue_level !== want.blue_level) begin
          $error("blue_level: expected %0d, got %0d", want.blue_level, got.blue_level);
          errors++;
        end
        if (got.light_on !== want.light_on) begin
          $error("light_on: expected %0d, got %0d", want.light_on, got.light_on);
          errors++;
        end
        if (got.color_index !== want.color_index) begin
          $error("color_index: expected %0d, got %0d", want.color_index, got.color_index);
          errors++;
        end
        if (got.peak_to_peak !== want.peak_to_peak) begin
          $error("peak_to_peak: expected %0d, got %0d", want.peak_to_peak,
                 got.peak_to_peak);
          errors++;
        end
        if (got.window_closed !== want.window_closed) begin
          $error("window_closed: expected %0d, got %0d", want.window_closed,
                 got.window_closed);
          errors++;
        end
        if (got.clap_seen !== want.clap_seen) begin
          $error("clap_seen: expected %0d, got %0d", want.clap_seen, got.clap_seen);
          errors++;
        end
        n_closed += int'(want.window_closed);
        n_claps += int'(want.clap_seen);
        n_dark += int'(!want.light_on);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // output side stalls
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (idle_en && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    plan_row_t              plan [$];
    logic [SampleWidth-1:0] thr;
    logic [TimerWidth-1:0]  sw;
    logic [TimerWidth-1:0]  cw;
    logic [SampleWidth-1:0] smp;
    logic                   tick;
    int                     n_items;
    int                     mode;
    int                     seg_left;
    int                     center;
    int                     v;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset state, then short bursts with tiny windows
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b1, ResetResult});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1023, 1'b0, 1'b1,
                     ResetResult});
    plan.push_back('{ROW_WRITE, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, REG_SAMPLE_WINDOW_MS, 16'd1, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, REG_CLAP_WINDOW_MS, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    // two claps toggle the lamp off
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1023, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1023, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    // one clap while dark is ignored
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd7, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd8, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    // two claps bring it back on
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    // single clap steps the color
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1023, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});
    // zero sampling window closes an empty window on every request
    plan.push_back('{ROW_WRITE, REG_SAMPLE_WINDOW_MS, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1023, 1'b1, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    // full-scale swing does not beat the top threshold
    plan.push_back('{ROW_WRITE, REG_CLAP_THRESHOLD, 16'd1023, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_WRITE, REG_SAMPLE_WINDOW_MS, 16'd1, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd1023, 1'b0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, REG_CLAP_THRESHOLD, 16'd0, 10'd0, 1'b1, 1'b0, '0});

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].sample, plan[i].tick, plan[i].typed, plan[i].result);
      end
    end

    // random phases, each with its own settings
    for (int p = 0; p < 9; p++) begin
      if (p == 0) begin
        thr = 10'd1023;
        sw = 16'hFFFF;
        cw = 16'hFFFF;
        n_items = 20;
      end else if (p == 1) begin
        thr = 10'd0;
        sw = 16'd1;
        cw = 16'd0;
        n_items = 60;
      end else begin
        thr = SampleWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(100, 700));
        sw = TimerWidth'($urandom_range(1, 6));
        cw = TimerWidth'($urandom_range(0, 25));
        n_items = 65;
      end
      drain_results();
      idle_en = (p % 3 != 2);
      write_reg(REG_CLAP_THRESHOLD, {6'd0, thr});
      write_reg(REG_SAMPLE_WINDOW_MS, sw);
      write_reg(REG_CLAP_WINDOW_MS, cw);
      seg_left = 0;
      mode = 0;
      center = 0;
      for (int k = 0; k < n_items; k++) begin
        // segments of loud swings, quiet hum or plain noise
        if (seg_left == 0) begin
          v = $urandom_range(0, 99);
          mode = (v < 50) ? 0 : (v < 85) ? 1 : 2;
          seg_left = $urandom_range(3, 20);
          center = $urandom_range(0, 1023);
        end
        seg_left--;
        case (mode)
          0: begin
            tick = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 1) == 0)
              smp = SampleWidth'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                      : $urandom_range(983, 1023));
            else
              smp = SampleWidth'($urandom_range(0, 1023));
          end
          1: begin
            tick = ($urandom_range(0, 2) != 0);
            v = center + int'($urandom_range(0, 16)) - 8;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            smp = v[SampleWidth-1:0];
          end
          default: begin
            tick = ($urandom_range(0, 1) != 0);
            smp = SampleWidth'($urandom_range(0, 1023));
          end
        endcase
        send_sample(smp, tick, 1'b0, '0);
      end
    end

    drain_results();
    $display("checked %0d sample requests under %0d register writes", n_requests, n_writes);
    $display("%0d windows closed, %0d claps counted, %0d results with the lamp dark",
             n_closed, n_claps, n_dark);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/csrgb_pkg.sv
sv/csrgb_apb_regs.sv
sv/clap_switch_rgb_controller.sv
dv/tb.sv
